FILE: sv/rdft_pkg.sv
// Package for the running DFT accumulator: command and configuration types,
// register indexes, opcodes and the quarter-wave sine table function.
// No dependencies.
`default_nettype none

package rdft_pkg;

    localparam int unsigned FREQ_W = 3;

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_FREQ_COUNT  = 3'd1;
    localparam logic [2:0] REG_POINT_COUNT = 3'd2;
    localparam logic [2:0] REG_DT_SCALE    = 3'd3;
    localparam logic [2:0] REG_FREQ_STEP_A = 3'd4;
    localparam logic [2:0] REG_FREQ_STEP_B = 3'd5;
    localparam logic [2:0] REG_FREQ_STEP_C = 3'd6;
    localparam logic [2:0] REG_FREQ_STEP_D = 3'd7;

    typedef enum logic [1:0] {
        KIND_ACC,
        KIND_READ,
        KIND_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        tstep;
        logic [9:0]         point;
        logic [1:0]         fsel;
        logic signed [23:0] sample;
    } cmd_t;

    typedef struct packed {
        logic             enable;
        logic [2:0]       freq_count;
        logic [10:0]      point_count;
        logic [15:0]      dt_scale;
        logic [3:0][31:0] freq_step;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PHASE,
        ST_TRIG,
        ST_MUL,
        ST_ADD,
        ST_RDATA,
        ST_CLEAR
    } state_t;

    // One entry of the quarter-wave table, built from a Taylor series in Q30.
    function automatic logic [14:0] quarter_entry(int unsigned i, int unsigned tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        begin
            x    = (64'd1686629713 * 64'(i)) >> tb;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 12; k++) begin
                if (term != 0) begin
                    term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                    if ((k % 2) == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767) begin
                v = 32767;
            end
            quarter_entry = 15'(v);
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/rdft_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
`default_nettype none

module rdft_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/rdft_front.sv
// Front end of the running DFT accumulator: accepts input transactions,
// drops those with no effect and queues commands. Depends on rdft_pkg.
`default_nettype none

module rdft_front #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [55:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire rdft_pkg::cfg_t    cfg,
    input  wire logic              init_busy,
    output logic                   q_valid,
    output rdft_pkg::cmd_t         q_cmd,
    input  wire logic              q_pop
);

    rdft_pkg::cmd_t q_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     count_reg, count_next;
    rdft_pkg::cmd_t cmd;
    logic           keep;
    logic           enq;
    logic           point_ok;

    always_comb begin
        cmd.tstep  = s_tdata[15:0];
        cmd.point  = s_tdata[25:16];
        cmd.fsel   = s_tdata[27:26];
        cmd.sample = $signed(s_tdata[51:28]);
        cmd.kind   = rdft_pkg::KIND_ACC;
        point_ok   = {22'b0, cmd.point} < 32'(MAX_POINTS);
        keep       = 1'b0;
        unique case (s_tuser)
            rdft_pkg::OP_ACC: begin
                cmd.kind = rdft_pkg::KIND_ACC;
                keep     = cfg.enable && point_ok && ({1'b0, cmd.point} < cfg.point_count);
            end
            rdft_pkg::OP_READ: begin
                cmd.kind = rdft_pkg::KIND_READ;
                keep     = 1'b1;
            end
            rdft_pkg::OP_CLEAR: begin
                cmd.kind = rdft_pkg::KIND_CLEAR;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2) && !init_busy;
    assign enq      = s_tvalid && s_tready && keep;
    assign q_valid  = count_reg != 2'd0;
    assign q_cmd    = q_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg ^ enq;
        rptr_next  = rptr_reg ^ q_pop;
        count_next = count_reg + 2'(enq) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq) begin
            q_reg[wptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rdft_back.sv
// Back end of the running DFT accumulator: sequencer for accumulate, read and
// clear commands, trigonometry, accumulator store and result register.
// Depends on rdft_pkg and rdft_ram.
`default_nettype none

module rdft_back #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_FREQS  = 4,
    parameter int TABLE_BITS = 10
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire rdft_pkg::cfg_t cfg,
    input  wire logic           q_valid,
    input  wire rdft_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                init_busy,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [103:0]        m_tdata
);

    localparam int DEPTH  = MAX_FREQS * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAB_N  = 1 << TABLE_BITS;
    localparam int IDX_W  = TABLE_BITS + 1;

    rdft_pkg::state_t state_reg, state_next;
    rdft_pkg::cmd_t   cmd_reg, cmd_next;
    logic [rdft_pkg::FREQ_W-1:0] f_reg, f_next;
    logic [rdft_pkg::FREQ_W-1:0] nf;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              init_reg, init_next;
    logic              ovf_reg, ovf_next;
    logic              rzero_reg, rzero_next;
    logic signed [40:0] sd_reg, sd_next;
    logic [31:0]        phase_reg, phase_next;
    logic signed [15:0] sn_reg, sn_next, cs_reg, cs_next;
    logic signed [56:0] pre_reg, pre_next, pim_reg, pim_next;
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic               out_ovf_reg, out_ovf_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [95:0]       mem_wdata, mem_rdata;

    logic [14:0] qtab [TAB_N+1];
    logic [1:0]  quad_s, quad_c;
    logic [IDX_W-1:0] idx, idx_m;
    logic signed [15:0] sin_v, cos_v;
    logic signed [56:0] rnd_re, rnd_im;
    logic signed [48:0] sum_re, sum_im;
    logic [47:0] new_re, new_im;
    logic        sat_re, sat_im;
    logic [ADDR_W-1:0] acc_addr;

    for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
        assign qtab[g] = rdft_pkg::quarter_entry(g, TABLE_BITS);
    end

    rdft_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign nf = (cfg.freq_count > 3'(MAX_FREQS)) ? 3'(MAX_FREQS) : cfg.freq_count;
    assign acc_addr = ADDR_W'(f_reg) * ADDR_W'(MAX_POINTS) + ADDR_W'(cmd_reg.point);

    // Quarter-wave lookup; cosine is the sine one quadrant further on.
    always_comb begin
        quad_s = phase_reg[31:30];
        quad_c = quad_s + 2'd1;
        idx    = {1'b0, phase_reg[29 -: TABLE_BITS]};
        idx_m  = IDX_W'(TAB_N) - idx;
        sin_v  = $signed({1'b0, quad_s[0] ? qtab[idx_m] : qtab[idx]});
        cos_v  = $signed({1'b0, quad_c[0] ? qtab[idx_m] : qtab[idx]});
        if (quad_s[1]) begin
            sin_v = -sin_v;
        end
        if (quad_c[1]) begin
            cos_v = -cos_v;
        end
    end

    // Round half up by 2^31 and add with saturation to 48 bits.
    always_comb begin
        rnd_re = (pre_reg + 57'sd1073741824) >>> 31;
        rnd_im = (-pim_reg + 57'sd1073741824) >>> 31;
        sum_re = {mem_rdata[47], mem_rdata[47:0]} + rnd_re[48:0];
        sum_im = {mem_rdata[95], mem_rdata[95:48]} + rnd_im[48:0];
        sat_re = sum_re[48] != sum_re[47];
        sat_im = sum_im[48] != sum_im[47];
        new_re = sat_re ? {sum_re[48], {47{~sum_re[48]}}} : sum_re[47:0];
        new_im = sat_im ? {sum_im[48], {47{~sum_im[48]}}} : sum_im[47:0];
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        f_next         = f_reg;
        clr_next       = clr_reg;
        init_next      = init_reg;
        ovf_next       = ovf_reg;
        rzero_next     = rzero_reg;
        sd_next        = sd_reg;
        phase_next     = phase_reg;
        sn_next        = sn_reg;
        cs_next        = cs_reg;
        pre_next       = pre_reg;
        pim_next       = pim_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_ovf_next   = out_ovf_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = acc_addr;
        mem_wdata      = {new_im, new_re};
        mem_re         = 1'b0;
        mem_raddr      = acc_addr;
        unique case (state_reg)
            rdft_pkg::ST_INIT, rdft_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    init_next  = 1'b0;
                    state_next = rdft_pkg::ST_IDLE;
                end
            end
            rdft_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.kind)
                        rdft_pkg::KIND_ACC: begin
                            f_next     = '0;
                            sd_next    = 41'(q_cmd.sample * $signed({1'b0, cfg.dt_scale}));
                            state_next = (nf == '0) ? rdft_pkg::ST_IDLE : rdft_pkg::ST_PHASE;
                        end
                        rdft_pkg::KIND_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(q_cmd.fsel) * ADDR_W'(MAX_POINTS)
                                       + ADDR_W'(q_cmd.point);
                            rzero_next = !(({30'b0, q_cmd.fsel} < 32'(MAX_FREQS))
                                        && ({22'b0, q_cmd.point} < 32'(MAX_POINTS)));
                            state_next = rdft_pkg::ST_RDATA;
                        end
                        rdft_pkg::KIND_CLEAR: begin
                            clr_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = rdft_pkg::ST_CLEAR;
                        end
                        default: state_next = rdft_pkg::ST_IDLE;
                    endcase
                end
            end
            rdft_pkg::ST_PHASE: begin
                mem_re     = 1'b1;
                phase_next = 32'(cmd_reg.tstep * cfg.freq_step[f_reg[1:0]]);
                state_next = rdft_pkg::ST_TRIG;
            end
            rdft_pkg::ST_TRIG: begin
                sn_next    = sin_v;
                cs_next    = cos_v;
                state_next = rdft_pkg::ST_MUL;
            end
            rdft_pkg::ST_MUL: begin
                pre_next   = 57'(sd_reg * cs_reg);
                pim_next   = 57'(sd_reg * sn_reg);
                state_next = rdft_pkg::ST_ADD;
            end
            rdft_pkg::ST_ADD: begin
                mem_we   = 1'b1;
                ovf_next = ovf_reg || sat_re || sat_im;
                f_next   = f_reg + 3'd1;
                state_next = (f_reg + 3'd1 == nf) ? rdft_pkg::ST_IDLE : rdft_pkg::ST_PHASE;
            end
            rdft_pkg::ST_RDATA: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_re_next    = rzero_reg ? '0 : mem_rdata[47:0];
                    out_im_next    = rzero_reg ? '0 : mem_rdata[95:48];
                    out_ovf_next   = ovf_reg;
                    state_next     = rdft_pkg::ST_IDLE;
                end
            end
            default: state_next = rdft_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rdft_pkg::ST_INIT;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            f_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            f_reg         <= f_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        rzero_reg   <= rzero_next;
        sd_reg      <= sd_next;
        phase_reg   <= phase_next;
        sn_reg      <= sn_next;
        cs_reg      <= cs_next;
        pre_reg     <= pre_next;
        pim_reg     <= pim_next;
        out_re_reg  <= out_re_next;
        out_im_reg  <= out_im_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign init_busy = init_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_ovf_reg, out_im_reg, out_re_reg};

endmodule

`default_nettype wire

FILE: sv/running_dft_accumulator.sv
// Top level of the running DFT accumulator: configuration registers, front
// end and back end. Depends on rdft_pkg, rdft_front, rdft_back.
//
//   Channel  Dir  Handshake          Payload
//   s_       in   s_tvalid/s_tready  s_tdata, s_tuser (opcode)
//   m_       out  m_tvalid/m_tready  m_tdata
//   cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// An accumulate transaction passes through the phase, trig, multiply and add
// states once per active frequency: each frequency is one read-modify-write of
// the accumulator RAM. A read transaction reads one entry, plus any wait on m_tready.
// A clear transaction sweeps all MAX_FREQS * MAX_POINTS entries, one per cycle.
// The same sweep runs after reset, with s_tready low throughout.
// A two-entry command queue lets the input side run ahead of the back end.
`default_nettype none

module running_dft_accumulator #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_FREQS  = 4,
    parameter int TABLE_BITS = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // time_step[15:0], point_index[25:16], freq_index[27:26], sample[51:28]
    input  wire logic [55:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // acc_real[47:0], acc_imag[95:48], overflow_seen[96]
    output logic [103:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    rdft_pkg::cfg_t cfg_reg, cfg_next;
    rdft_pkg::cmd_t q_cmd;
    logic           q_valid;
    logic           q_pop;
    logic           init_busy;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                rdft_pkg::REG_ENABLE:      cfg_next.enable       = cfg_wdata[0];
                rdft_pkg::REG_FREQ_COUNT:  cfg_next.freq_count   = cfg_wdata[2:0];
                rdft_pkg::REG_POINT_COUNT: cfg_next.point_count  = cfg_wdata[10:0];
                rdft_pkg::REG_DT_SCALE:    cfg_next.dt_scale     = cfg_wdata[15:0];
                rdft_pkg::REG_FREQ_STEP_A: cfg_next.freq_step[0] = cfg_wdata;
                rdft_pkg::REG_FREQ_STEP_B: cfg_next.freq_step[1] = cfg_wdata;
                rdft_pkg::REG_FREQ_STEP_C: cfg_next.freq_step[2] = cfg_wdata;
                rdft_pkg::REG_FREQ_STEP_D: cfg_next.freq_step[3] = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.freq_count  <= 3'd1;
            cfg_reg.point_count <= 11'd1024;
            cfg_reg.dt_scale    <= 16'hFFFF;
            cfg_reg.freq_step   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rdft_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg_reg),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    rdft_back #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_FREQS  (MAX_FREQS),
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sv/rdft_checker.sv
// Port-level checks for the running DFT accumulator, bound to the top level.
// Depends on running_dft_accumulator.
`default_nettype none

module rdft_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [55:0]  s_tdata,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         cfg_we,
    input wire logic [2:0]   cfg_addr,
    input wire logic [31:0]  cfg_wdata
);

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The store is swept after reset, so no input transaction is taken then.
    a_reset_blocks_in: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during the post-reset sweep");

    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind running_dft_accumulator rdft_checker u_rdft_checker (.*);

`default_nettype wire
